[rtl/xbr_pkg.sv]
package xbr_pkg;

  // address space of the receive buffer
  localparam int unsigned ADDR_BITS   = 20;
  localparam int unsigned COUNT_BITS  = ADDR_BITS + 1;
  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned INDEX_BITS  = $clog2(BLOCK_BYTES);
  localparam int unsigned TICK_BITS   = 24;

  localparam logic [COUNT_BITS-1:0] SPAN_BYTES  = COUNT_BITS'(1) << ADDR_BITS;
  localparam logic [COUNT_BITS-1:0] BLOCK_COUNT = COUNT_BITS'(BLOCK_BYTES);
  localparam logic [INDEX_BITS-1:0] LAST_INDEX  = INDEX_BITS'(BLOCK_BYTES - 1);
  localparam logic [TICK_BITS-1:0]  NAK_INTERVAL_RESET = TICK_BITS'(200000);

  // protocol characters
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_NAK  = 8'h15;
  localparam logic [7:0] CH_CAN  = 8'h18;
  localparam logic [7:0] CPL_SUM = 8'hff;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // receiver phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_NUMBER = 3'd1;
  localparam logic [2:0] PH_COMPL  = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CHECK  = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_CANCEL = 3'd6;
  localparam logic [2:0] PH_FAIL   = 3'd7;

  // transfer status codes
  localparam logic [1:0] ST_BUSY   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_CANCEL = 2'd2;
  localparam logic [1:0] ST_FAIL   = 2'd3;

  typedef struct packed {
    logic                  action;
    logic [7:0]            rx_byte;
  } item_t;

  typedef struct packed {
    logic                  send_valid;
    logic [7:0]            send_byte;
    logic                  write_valid;
    logic [ADDR_BITS-1:0]  write_addr;
    logic [7:0]            write_data;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] byte_count;
  } result_t;

endpackage

[rtl/xmodem_block_receiver.sv]
// XMODEM receiver (8-bit additive checksum). Each input transaction is a received
// byte (action 0) or an idle poll tick (action 1), and each one yields exactly one
// result transaction carrying the response byte to send (ACK/NAK), an optional
// buffer write (address = accepted bytes + index in block), the transfer status
// and the running count of accepted bytes. Before the first SOH a NAK is emitted
// every nak_interval idle ticks; nak_interval is written through cfg_we_i and
// cfg_wdata_i, and the user must write it only while the block is idle; the block
// itself does not enforce this. The design is two registers deep: an input
// register and a result register with the protocol state updated in between.
// One transaction is taken every cycle as long as the result side is not stalled.
// in_stall_o only rises when both registers are full and out_stall_i holds the
// result. After done, cancel or failure every input is consumed and the final
// status is repeated until reset.
module xmodem_block_receiver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [xbr_pkg::TICK_BITS-1:0]      cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic [7:0]                         rx_byte_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               send_valid_o,
  output logic [7:0]                         send_byte_o,
  output logic                               write_valid_o,
  output logic [xbr_pkg::ADDR_BITS-1:0]      write_addr_o,
  output logic [7:0]                         write_data_o,
  output logic [1:0]                         status_o,
  output logic [xbr_pkg::COUNT_BITS-1:0]     byte_count_o
);

  xbr_pkg::item_t   in_item;
  xbr_pkg::item_t   stage_item;
  xbr_pkg::result_t core_res;
  xbr_pkg::result_t out_res;
  logic             stage_vld;
  logic             out_ready;
  logic             fire;

  assign in_item.action  = action_i;
  assign in_item.rx_byte = rx_byte_i;

  // the input register moves on when the result register has room
  assign fire       = stage_vld && out_ready;
  assign in_stall_o = stage_vld && !out_ready;

  xbr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_item_i  (in_item),
    .take_i     (fire),
    .vld_o      (stage_vld),
    .item_o     (stage_item)
  );

  // protocol state and the per-transaction decision
  xbr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (stage_item),
    .result_o    (core_res)
  );

  xbr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (core_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .ready_o     (out_ready),
    .result_o    (out_res)
  );

  assign send_valid_o  = out_res.send_valid;
  assign send_byte_o   = out_res.send_byte;
  assign write_valid_o = out_res.write_valid;
  assign write_addr_o  = out_res.write_addr;
  assign write_data_o  = out_res.write_data;
  assign status_o      = out_res.status;
  assign byte_count_o  = out_res.byte_count;

  // a response is only ever ACK or NAK
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o |->
      send_byte_o == xbr_pkg::CH_ACK || send_byte_o == xbr_pkg::CH_NAK)
    else $error("response byte is neither ACK nor NAK");

  // a data write never comes with a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(write_valid_o && send_valid_o))
    else $error("write and response in one result");

  // writes only happen while the transfer is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> status_o == xbr_pkg::ST_BUSY)
    else $error("write after the transfer finished");

  // the input side stalls only when the result register is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule

[rtl/xbr_in_stage.sv]
module xbr_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  xbr_pkg::item_t in_item_i,
  input  logic          take_i,
  output logic          vld_o,
  output xbr_pkg::item_t item_o
);

  logic           vld_q, vld_d;
  xbr_pkg::item_t item_q;
  logic           load;

  assign load = in_valid_i && !in_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

[rtl/xbr_core.sv]
module xbr_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [xbr_pkg::TICK_BITS-1:0] cfg_wdata_i,
  input  logic                         fire_i,
  input  xbr_pkg::item_t               item_i,
  output xbr_pkg::result_t             result_o
);

  logic [2:0]                        phase_q, phase_d;
  logic [7:0]                        exp_blk_q, exp_blk_d;
  logic                              got_first_q, got_first_d;
  logic [7:0]                        rcv_blk_q, rcv_blk_d;
  logic [xbr_pkg::INDEX_BITS-1:0]    index_q, index_d;
  logic [7:0]                        sum_q, sum_d;
  logic [xbr_pkg::COUNT_BITS-1:0]    accepted_q, accepted_d;
  logic [xbr_pkg::TICK_BITS-1:0]     ticks_q, ticks_d;
  logic [xbr_pkg::TICK_BITS-1:0]     interval_q;
  logic [xbr_pkg::TICK_BITS-1:0]     ticks_inc;
  logic [xbr_pkg::COUNT_BITS:0]      block_end;
  xbr_pkg::result_t                  res;

  assign ticks_inc = ticks_q + xbr_pkg::TICK_BITS'(1);
  assign block_end = {1'b0, accepted_q} + {1'b0, xbr_pkg::BLOCK_COUNT};

  always_comb begin
    phase_d     = phase_q;
    exp_blk_d   = exp_blk_q;
    got_first_d = got_first_q;
    rcv_blk_d   = rcv_blk_q;
    index_d     = index_q;
    sum_d       = sum_q;
    accepted_d  = accepted_q;
    ticks_d     = ticks_q;
    res         = '0;

    if (phase_q == xbr_pkg::PH_DONE || phase_q == xbr_pkg::PH_CANCEL ||
        phase_q == xbr_pkg::PH_FAIL) begin
      // finished: hold everything
    end else if (item_i.action == xbr_pkg::ACT_TICK) begin
      if (phase_q == xbr_pkg::PH_HEADER && !got_first_q) begin
        ticks_d = ticks_inc;
        if (ticks_inc >= interval_q) begin
          ticks_d       = '0;
          res.send_valid = 1'b1;
          res.send_byte  = xbr_pkg::CH_NAK;
        end
      end
    end else begin
      ticks_d = '0;
      case (phase_q)
        xbr_pkg::PH_HEADER: begin
          if (item_i.rx_byte == xbr_pkg::CH_EOT) begin
            res.send_valid = 1'b1;
            res.send_byte  = xbr_pkg::CH_ACK;
            phase_d        = xbr_pkg::PH_DONE;
          end else if (item_i.rx_byte == xbr_pkg::CH_CAN) begin
            phase_d = xbr_pkg::PH_CANCEL;
          end else if (item_i.rx_byte == xbr_pkg::CH_SOH) begin
            got_first_d = 1'b1;
            if (block_end > {1'b0, xbr_pkg::SPAN_BYTES}) begin
              phase_d = xbr_pkg::PH_FAIL;
            end else begin
              phase_d = xbr_pkg::PH_NUMBER;
            end
          end else if (got_first_q) begin
            phase_d = xbr_pkg::PH_FAIL;
          end
        end
        xbr_pkg::PH_NUMBER: begin
          rcv_blk_d = item_i.rx_byte;
          if (item_i.rx_byte != exp_blk_q) begin
            res.send_valid = 1'b1;
            res.send_byte  = xbr_pkg::CH_NAK;
            phase_d        = xbr_pkg::PH_HEADER;
          end else begin
            phase_d = xbr_pkg::PH_COMPL;
          end
        end
        xbr_pkg::PH_COMPL: begin
          if ((rcv_blk_q ^ item_i.rx_byte) != xbr_pkg::CPL_SUM) begin
            res.send_valid = 1'b1;
            res.send_byte  = xbr_pkg::CH_NAK;
            phase_d        = xbr_pkg::PH_HEADER;
          end else begin
            index_d = '0;
            sum_d   = '0;
            phase_d = xbr_pkg::PH_DATA;
          end
        end
        xbr_pkg::PH_DATA: begin
          res.write_valid = 1'b1;
          res.write_addr  = xbr_pkg::ADDR_BITS'(accepted_q +
                            xbr_pkg::COUNT_BITS'(index_q));
          res.write_data  = item_i.rx_byte;
          sum_d           = sum_q + item_i.rx_byte;
          if (index_q == xbr_pkg::LAST_INDEX) begin
            index_d = '0;
            phase_d = xbr_pkg::PH_CHECK;
          end else begin
            index_d = index_q + xbr_pkg::INDEX_BITS'(1);
          end
        end
        xbr_pkg::PH_CHECK: begin
          res.send_valid = 1'b1;
          if (sum_q == item_i.rx_byte) begin
            res.send_byte = xbr_pkg::CH_ACK;
            exp_blk_d     = exp_blk_q + 8'd1;
            accepted_d    = accepted_q + xbr_pkg::BLOCK_COUNT;
          end else begin
            res.send_byte = xbr_pkg::CH_NAK;
          end
          sum_d   = '0;
          phase_d = xbr_pkg::PH_HEADER;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    case (phase_d)
      xbr_pkg::PH_DONE:   res.status = xbr_pkg::ST_DONE;
      xbr_pkg::PH_CANCEL: res.status = xbr_pkg::ST_CANCEL;
      xbr_pkg::PH_FAIL:   res.status = xbr_pkg::ST_FAIL;
      default:            res.status = xbr_pkg::ST_BUSY;
    endcase
    res.byte_count = accepted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= xbr_pkg::PH_HEADER;
      exp_blk_q   <= 8'd1;
      got_first_q <= 1'b0;
      rcv_blk_q   <= '0;
      index_q     <= '0;
      sum_q       <= '0;
      accepted_q  <= '0;
      ticks_q     <= '0;
      interval_q  <= xbr_pkg::NAK_INTERVAL_RESET;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        phase_q     <= phase_d;
        exp_blk_q   <= exp_blk_d;
        got_first_q <= got_first_d;
        rcv_blk_q   <= rcv_blk_d;
        index_q     <= index_d;
        sum_q       <= sum_d;
        accepted_q  <= accepted_d;
        ticks_q     <= ticks_d;
      end
    end
  end

  assign result_o = res;

endmodule

[rtl/xbr_out_stage.sv]
module xbr_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  xbr_pkg::result_t result_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             ready_o,
  output xbr_pkg::result_t result_o
);

  logic             vld_q, vld_d;
  xbr_pkg::result_t res_q;

  // room when empty or the held result leaves this cycle
  assign ready_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

[tb/tb_xmodem_block_receiver.sv]
`timescale 1ns / 100ps

module tb_xmodem_block_receiver;
  import xbr_pkg::*;

  // clock, run length and pacing
  localparam int unsigned CLK_HALF_NS  = 5;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned LIMIT_NS     = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES = 1950;
  localparam int unsigned TAIL_ITEMS   = 16;
  localparam int unsigned MAX_PRINTS   = 60;
  localparam int unsigned DIR_ROWS     = 21;

  typedef enum logic [1:0] {ROW_TICK, ROW_BYTE, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {BLK_GOOD, BLK_BAD_SUM, BLK_BAD_NUMBER, BLK_BAD_COMPL} blk_kind_e;
  typedef enum logic [1:0] {END_EOT, END_CAN, END_JUNK} end_kind_e;

  // one line of the directed table; the typed expectation only covers rows
  // where no block has been accepted yet, so write fields and count are zero
  typedef struct packed {
    row_kind_e            kind;
    logic [TICK_BITS-1:0] value;
    logic                 known;
    logic                 send_valid;
    logic [7:0]           send_byte;
    logic [1:0]           status;
  } dir_row_t;

  // dut ports, all inputs known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [TICK_BITS-1:0]  cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  action_i    = ACT_TICK;
  logic [7:0]            rx_byte_i   = '0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  send_valid_o;
  logic [7:0]            send_byte_o;
  logic                  write_valid_o;
  logic [ADDR_BITS-1:0]  write_addr_o;
  logic [7:0]            write_data_o;
  logic [1:0]            status_o;
  logic [COUNT_BITS-1:0] byte_count_o;

  // receiver state as the testbench sees it, reset values included
  logic [2:0]            rx_phase  = PH_HEADER;
  logic [7:0]            want_blk  = 8'd1;
  logic                  seen_soh  = 1'b0;
  logic [7:0]            got_blk   = '0;
  logic [INDEX_BITS-1:0] data_idx  = '0;
  logic [7:0]            data_sum  = '0;
  logic [COUNT_BITS-1:0] acc_bytes = '0;
  logic [TICK_BITS-1:0]  tick_cnt  = '0;
  logic [TICK_BITS-1:0]  nak_every = NAK_INTERVAL_RESET;

  // results still owed by the dut, oldest first
  result_t     pending_results[$];
  dir_row_t    dir_rows[DIR_ROWS];
  int unsigned err_cnt       = 0;
  int unsigned src_idle_pct  = 8;
  int unsigned sink_idle_pct = 68;
  int unsigned hold_left     = 0;
  int unsigned data_bytes    = 0;

  xmodem_block_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .send_valid_o  (send_valid_o),
    .send_byte_o   (send_byte_o),
    .write_valid_o (write_valid_o),
    .write_addr_o  (write_addr_o),
    .write_data_o  (write_data_o),
    .status_o      (status_o),
    .byte_count_o  (byte_count_o)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // walks the receiver state by one input transaction and returns what
  // the dut must produce for it
  function automatic result_t xmodem_rx_predict(input logic act, input logic [7:0] b);
    result_t r;
    r = '0;
    if (rx_phase >= PH_DONE) begin
      // transfer over: everything is swallowed, final status holds
    end else if (act == ACT_TICK) begin
      // ticks only matter while soliciting the first block
      if (rx_phase == PH_HEADER && !seen_soh) begin
        tick_cnt = tick_cnt + TICK_BITS'(1);
        if (tick_cnt >= nak_every) begin
          tick_cnt     = '0;
          r.send_valid = 1'b1;
          r.send_byte  = CH_NAK;
        end
      end
    end else begin
      tick_cnt = '0;
      case (rx_phase)
        PH_HEADER: begin
          if (b == CH_EOT) begin
            r.send_valid = 1'b1;
            r.send_byte  = CH_ACK;
            rx_phase     = PH_DONE;
          end else if (b == CH_CAN) begin
            rx_phase = PH_CANCEL;
          end else if (b == CH_SOH) begin
            seen_soh = 1'b1;
            // a block that would run past the buffer end kills the transfer
            if (32'(acc_bytes) + BLOCK_BYTES > 32'(SPAN_BYTES)) rx_phase = PH_FAIL;
            else rx_phase = PH_NUMBER;
          end else if (seen_soh) begin
            rx_phase = PH_FAIL;
          end
        end
        PH_NUMBER: begin
          got_blk = b;
          if (b != want_blk) begin
            r.send_valid = 1'b1;
            r.send_byte  = CH_NAK;
            rx_phase     = PH_HEADER;
          end else begin
            rx_phase = PH_COMPL;
          end
        end
        PH_COMPL: begin
          if ((got_blk ^ b) != CPL_SUM) begin
            r.send_valid = 1'b1;
            r.send_byte  = CH_NAK;
            rx_phase     = PH_HEADER;
          end else begin
            data_idx = '0;
            data_sum = '0;
            rx_phase = PH_DATA;
          end
        end
        PH_DATA: begin
          r.write_valid = 1'b1;
          r.write_addr  = ADDR_BITS'(acc_bytes + COUNT_BITS'(data_idx));
          r.write_data  = b;
          data_sum      = data_sum + b;
          if (data_idx == LAST_INDEX) rx_phase = PH_CHECK;
          data_idx = data_idx + INDEX_BITS'(1);
        end
        default: begin
          // checksum byte closes the block
          r.send_valid = 1'b1;
          if (data_sum == b) begin
            r.send_byte = CH_ACK;
            want_blk    = want_blk + 8'd1;
            acc_bytes   = acc_bytes + BLOCK_COUNT;
          end else begin
            r.send_byte = CH_NAK;
          end
          data_sum = '0;
          rx_phase = PH_HEADER;
        end
      endcase
    end
    case (rx_phase)
      PH_DONE:   r.status = ST_DONE;
      PH_CANCEL: r.status = ST_CANCEL;
      PH_FAIL:   r.status = ST_FAIL;
      default:   r.status = ST_BUSY;
    endcase
    r.byte_count = acc_bytes;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want_v);
    if (got !== want_v) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want_v));
  endtask

  // offers one input transaction, waits for it to be taken, then books the
  // result it must cause (the typed one where the table gives it)
  task automatic push_item(input logic act, input logic [7:0] b, input logic typed,
                           input result_t typed_res);
    result_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    r = xmodem_rx_predict(act, b);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // a received byte, now and then preceded by a stray poll tick
  task automatic offer_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < 5) push_item(ACT_TICK, 8'($urandom), 1'b0, '0);
    push_item(ACT_BYTE, b, 1'b0, '0);
    data_bytes++;
  endtask

  // register write only once the dut has drained
  task automatic write_interval(input logic [TICK_BITS-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    nak_every = v;
  endtask

  // one block from SOH on; faulty blocks stop where the dut gives up
  task automatic send_block(input blk_kind_e kind);
    logic [7:0] num;
    logic [7:0] sum;
    logic [7:0] d;
    num = want_blk;
    if (kind == BLK_BAD_NUMBER) num = want_blk + 8'($urandom_range(1, 255));
    offer_byte(CH_SOH);
    offer_byte(num);
    if (kind != BLK_BAD_NUMBER) begin
      if (kind == BLK_BAD_COMPL) begin
        offer_byte(~num ^ 8'($urandom_range(1, 255)));
      end else begin
        offer_byte(~num);
        sum = '0;
        repeat (BLOCK_BYTES) begin
          d   = 8'($urandom);
          sum = sum + d;
          offer_byte(d);
        end
        if (kind == BLK_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
        offer_byte(sum);
      end
    end
  endtask

  // mostly clean blocks, with retransmit-provoking faults mixed in
  task automatic run_blocks(input int unsigned upto);
    int unsigned pick;
    while (data_bytes < upto) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) send_block(BLK_GOOD);
      else if (pick < 82) send_block(BLK_BAD_SUM);
      else if (pick < 91) send_block(BLK_BAD_NUMBER);
      else send_block(BLK_BAD_COMPL);
    end
  endtask

  // result side: random stalls, plus one long hold-off on request so the
  // dut fills up and pushes back on its input
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < sink_idle_pct);
      end
    end
  end

  // result checker: every result transaction against the oldest booking
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", status_o));
      end else begin
        want = pending_results.pop_front();
        check_field("send_valid", 32'(send_valid_o), 32'(want.send_valid));
        check_field("send_byte", 32'(send_byte_o), 32'(want.send_byte));
        check_field("write_valid", 32'(write_valid_o), 32'(want.write_valid));
        check_field("write_addr", 32'(write_addr_o), 32'(want.write_addr));
        check_field("write_data", 32'(write_data_o), 32'(want.write_data));
        check_field("status", 32'(status_o), 32'(want.status));
        check_field("byte_count", 32'(byte_count_o), 32'(want.byte_count));
      end
    end
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned row;
    result_t     typed_res;
    end_kind_e   fin;
    logic [7:0]  junk;

    dir_rows = '{
      // default interval is far off, a first tick sends nothing
      '{ROW_TICK, 24'h00005a, 1'b1, 1'b0, 8'h00,  ST_BUSY},
      // line noise before the first block is dropped
      '{ROW_BYTE, 24'h000000, 1'b1, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_BYTE, 24'h0000ff, 1'b1, 1'b0, 8'h00,  ST_BUSY},
      // shortest interval: NAK on every tick
      '{ROW_CFG,  24'd1,      1'b0, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_TICK, 24'h0000a5, 1'b1, 1'b1, CH_NAK, ST_BUSY},
      '{ROW_TICK, 24'h0000ff, 1'b1, 1'b1, CH_NAK, ST_BUSY},
      // zero interval acts like one
      '{ROW_CFG,  24'd0,      1'b0, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_TICK, 24'h000000, 1'b1, 1'b1, CH_NAK, ST_BUSY},
      // longest interval
      '{ROW_CFG,  24'hffffff, 1'b0, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_TICK, 24'h000011, 1'b1, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_TICK, 24'h000022, 1'b1, 1'b0, 8'h00,  ST_BUSY},
      // interval of two, a received byte restarts the tick count
      '{ROW_CFG,  24'd2,      1'b0, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_BYTE, 24'h000080, 1'b1, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_TICK, 24'h000033, 1'b1, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_TICK, 24'h000044, 1'b1, 1'b1, CH_NAK, ST_BUSY},
      // wrong block number is refused at once
      '{ROW_BYTE, 24'(CH_SOH), 1'b1, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_BYTE, 24'h000002, 1'b1, 1'b1, CH_NAK, ST_BUSY},
      // once a block has started, ticks no longer solicit
      '{ROW_TICK, 24'h000001, 1'b1, 1'b0, 8'h00,  ST_BUSY},
      // complement that does not match the number
      '{ROW_BYTE, 24'(CH_SOH), 1'b1, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_BYTE, 24'h000001, 1'b1, 1'b0, 8'h00,  ST_BUSY},
      '{ROW_BYTE, 24'h000000, 1'b1, 1'b1, CH_NAK, ST_BUSY}
    };

    // first stretch: sender idles a little, receiver a lot
    src_idle_pct  = 8;
    sink_idle_pct = 68;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (row = 0; row < DIR_ROWS; row++) begin
      if (dir_rows[row].kind == ROW_CFG) begin
        write_interval(dir_rows[row].value);
      end else begin
        typed_res            = '0;
        typed_res.send_valid = dir_rows[row].send_valid;
        typed_res.send_byte  = dir_rows[row].send_byte;
        typed_res.status     = dir_rows[row].status;
        push_item((dir_rows[row].kind == ROW_TICK) ? ACT_TICK : ACT_BYTE,
                  dir_rows[row].value[7:0], dir_rows[row].known, typed_res);
      end
    end

    // random blocks; the long hold-off hits while the sender keeps offering
    hold_left = HOLD_CYCLES;
    run_blocks(RANDOM_BYTES / 3);

    // second stretch: roles swapped; interval write has no effect any more
    write_interval(24'($urandom_range(1, 24'hffffff)));
    src_idle_pct  = 68;
    sink_idle_pct = 8;
    run_blocks(2 * RANDOM_BYTES / 3);

    // last stretch at full rate
    write_interval(NAK_INTERVAL_RESET);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_blocks(RANDOM_BYTES);

    // end the transfer one of the three ways, then show the status sticks
    fin = end_kind_e'($urandom_range(0, 2));
    case (fin)
      END_EOT: push_item(ACT_BYTE, CH_EOT, 1'b0, '0);
      END_CAN: push_item(ACT_BYTE, CH_CAN, 1'b0, '0);
      default: begin
        do junk = 8'($urandom); while (junk == CH_SOH || junk == CH_EOT || junk == CH_CAN);
        push_item(ACT_BYTE, junk, 1'b0, '0);
      end
    endcase
    repeat (TAIL_ITEMS) push_item(1'($urandom), 8'($urandom), 1'b0, '0);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
